FILE: rtl/bblur_pkg.sv
// ----------------------------------------------------------------------------
// bblur_pkg
// Shared types, constants and helpers for the streaming 3x3 box blur core.
// ----------------------------------------------------------------------------
package bblur_pkg;

    // Default maximum frame size handed to the core parameters.
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // Configuration registers.
    localparam int              CFG_W      = 11;
    localparam logic [CFG_W-1:0] RST_WIDTH  = 11'd800;
    localparam logic [CFG_W-1:0] RST_HEIGHT = 11'd600;
    localparam int              APB_AW     = 3;
    localparam int              APB_DW     = 32;

    // Register index codes, taken from paddr[2].
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Pixel and sum widths. A channel sum of nine bytes fits in 12 bits.
    localparam int         PIX_W  = 24;
    localparam int         SUM_W  = 12;
    localparam int         POS_W  = 10;
    localparam logic [7:0] ALPHA  = 8'hFF;

    // Division by 9: multiply by ceil(2^16 / 9) and keep bits 23:16.
    // Exact for every sum below 2304.
    localparam int          DIV9_W   = 14;
    localparam logic [DIV9_W-1:0] DIV9_MUL = 14'd7282;

    typedef logic [PIX_W-1:0] t_rgb;

    // Boundary flags of the position of one item.
    typedef struct packed {
        logic c_ge1;
        logic c_ge2;
        logic r_ge1;
        logic r_ge2;
    } t_edge;

    // Side information that travels with one result.
    typedef struct packed {
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             last;
        logic             done;
    } t_res_tag;

    function automatic logic [7:0] div9(input logic [SUM_W-1:0] s);
        logic [SUM_W+DIV9_W-1:0] p;
        p = {{DIV9_W{1'b0}}, s} * {{SUM_W{1'b0}}, DIV9_MUL};
        return p[23:16];
    endfunction

endpackage

FILE: rtl/box_blur_3x3_rgb_core.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_core
// Streaming 3x3 box blur of RGBA8888 raster frames with two line stores.
// ----------------------------------------------------------------------------
// The core takes one pixel per clock in raster order while not held, and
// gives the 3x3 box blur of each pixel, one row and one column behind the
// input, with pixels outside the frame counted as zero and every sum divided
// by 9. Most input transactions cause at most one result and are taken back
// to back at one per cycle while the output does not stall. An input in the
// last column or the last row can cause up to four results, and because the
// result path emits one result per cycle, such an input holds the core until
// its results are out. Both line stores share one 48-bit wide memory that is
// read when a pixel is accepted and written back when that pixel moves into
// the window, in the next cycle when nothing stalls, so the sustained rate is
// set by that single read port and by the one-result-per-cycle output path.
// A result passes the stage 1, window, sum and output registers. The line
// stores need no clearing after reset; rows above the frame are masked out.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_core
    import bblur_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    // Pixel input
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,  // in_pixel[31:0]
    input  logic              s_axis_tuser,  // start_of_frame
    // Blurred pixel output
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [55:0]       m_axis_tdata,  // out_pixel[31:0], out_col[41:32],
                                             // out_row[51:42], zero[55:52]
    output logic              m_axis_tlast,  // last_of_run
    output logic              m_axis_tuser   // frame_done
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int EW = (WW > CFG_W) ? WW : CFG_W;
    localparam int EH = (HW > CFG_W) ? HW : CFG_W;
    localparam int XC = (CW > POS_W) ? CW : POS_W;
    localparam int XR = (RW > POS_W) ? RW : POS_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_WIDTH;
            r_frame_height <= RST_HEIGHT;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FRAME_WIDTH:  prdata = APB_DW'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DW'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    // Effective frame size: zero acts as one, large values clamp to the maximum.
    logic [EW-1:0] w_ext;
    logic [EH-1:0] h_ext;
    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;

    always_comb begin
        if (r_frame_width == '0) begin
            w_ext = EW'(1);
        end else if (EW'(r_frame_width) > EW'(MAX_WIDTH)) begin
            w_ext = EW'(MAX_WIDTH);
        end else begin
            w_ext = EW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_ext = EH'(1);
        end else if (EH'(r_frame_height) > EH'(MAX_HEIGHT)) begin
            h_ext = EH'(MAX_HEIGHT);
        end else begin
            h_ext = EH'(r_frame_height);
        end
    end

    assign eff_w = w_ext[WW-1:0];
    assign eff_h = h_ext[HW-1:0];

    // ------------------------------------------------------------------
    // Position counters and result selection at acceptance
    // ------------------------------------------------------------------
    logic          acc;
    logic          s1_adv;
    logic [CW-1:0] r_col_cnt;
    logic [RW-1:0] r_row_cnt;
    logic [WW-1:0] col_a, col_b, col_n;
    logic [HW-1:0] row_a, row_b, row_c, row_n;
    logic          wrap_c;
    logic          last_col, last_row;
    t_edge         acc_edge;
    logic [3:0]    acc_kinds;
    logic [CW-1:0] acc_c;
    logic [RW-1:0] acc_r;

    assign acc = s_axis_tvalid && s_axis_tready;

    always_comb begin
        col_a  = s_axis_tuser ? '0 : WW'(r_col_cnt);
        row_a  = s_axis_tuser ? '0 : HW'(r_row_cnt);
        wrap_c = (col_a >= eff_w);
        col_b  = wrap_c ? '0 : col_a;
        row_b  = wrap_c ? row_a + HW'(1) : row_a;
        row_c  = (row_b >= eff_h) ? '0 : row_b;
        acc_c  = col_b[CW-1:0];
        acc_r  = row_c[RW-1:0];

        // Position of the next transaction, wrapping at the frame end.
        col_n = col_b + WW'(1);
        row_n = row_c;
        if (col_n >= eff_w) begin
            col_n = '0;
            row_n = row_c + HW'(1);
            if (row_n >= eff_h) begin
                row_n = '0;
            end
        end

        last_col       = (col_b == eff_w - WW'(1));
        last_row       = (row_c == eff_h - HW'(1));
        acc_edge.c_ge1 = (col_b != '0);
        acc_edge.c_ge2 = (col_b > WW'(1));
        acc_edge.r_ge1 = (row_c != '0);
        acc_edge.r_ge2 = (row_c > HW'(1));

        // Results in raster order: up-left, up, left, centre.
        acc_kinds[0] = acc_edge.c_ge1 && acc_edge.r_ge1;
        acc_kinds[1] = last_col && acc_edge.r_ge1;
        acc_kinds[2] = last_row && acc_edge.c_ge1;
        acc_kinds[3] = last_row && last_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (acc) begin
            r_col_cnt <= col_n[CW-1:0];
            r_row_cnt <= row_n[RW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line store read. Upper row in the high half, lower row low.
    // ------------------------------------------------------------------
    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_ram_q;
    logic [2*PIX_W-1:0] r_fwd_word;
    logic [2*PIX_W-1:0] rd_word;
    logic [2*PIX_W-1:0] wr_word;
    logic               r_s1_valid;
    logic               r_s1_fwd;
    logic [CW-1:0]      r_s1_c;
    logic [RW-1:0]      r_s1_r;
    logic [3:0]         r_s1_kinds;
    t_edge              r_s1_edge;
    t_rgb               r_s1_rgb;

    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign rd_word       = r_s1_fwd ? r_fwd_word : r_ram_q;
    assign wr_word       = {rd_word[PIX_W-1:0], r_s1_rgb};

    // Read at acceptance, write back when the pixel moves into the window.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_ram_q <= mem[acc_c];
        end
        if (s1_adv) begin
            mem[r_s1_c] <= wr_word;
        end
    end

    // Forward the written word when the next pixel reads the same entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_fwd   <= 1'b0;
        end else if (acc) begin
            r_s1_valid <= 1'b1;
            r_s1_fwd   <= s1_adv && (acc_c == r_s1_c);
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
            r_s1_fwd   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_c     <= acc_c;
            r_s1_r     <= acc_r;
            r_s1_kinds <= acc_kinds;
            r_s1_edge  <= acc_edge;
            r_s1_rgb   <= s_axis_tdata[31:8];
            r_fwd_word <= wr_word;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: 3x3 window and result sequencing
    // ------------------------------------------------------------------
    t_rgb          r_win [9];
    logic [3:0]    r_pend;
    logic [CW-1:0] r_s2_c;
    logic [RW-1:0] r_s2_r;
    t_edge         r_s2_edge;
    logic [3:0]    pend_rest;
    logic [3:0]    sel;
    logic          s2_emit;
    logic          sum_rdy;

    assign pend_rest = r_pend & (r_pend - 4'd1);
    assign sel       = r_pend & ~(r_pend - 4'd1);
    assign s2_emit   = (r_pend != '0) && sum_rdy;
    assign s1_adv    = r_s1_valid && ((r_pend == '0) || (s2_emit && (pend_rest == '0)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_adv) begin
            r_pend <= r_s1_kinds;
            for (int j = 0; j < 3; j++) begin
                r_win[j*3]   <= r_win[j*3+1];
                r_win[j*3+1] <= r_win[j*3+2];
            end
            r_win[2] <= rd_word[2*PIX_W-1:PIX_W];
            r_win[5] <= rd_word[PIX_W-1:0];
            r_win[8] <= r_s1_rgb;
        end else if (s2_emit) begin
            r_pend <= pend_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_c    <= r_s1_c;
            r_s2_r    <= r_s1_r;
            r_s2_edge <= r_s1_edge;
        end
    end

    // Masked channel sums of the result being emitted.
    logic [2:0]       colok, rowok;
    logic             excl_k0, excl_j0;
    logic [SUM_W-1:0] sum_r, sum_g, sum_b;
    logic [CW-1:0]    res_c;
    logic [RW-1:0]    res_r;
    logic [XC-1:0]    res_cx;
    logic [XR-1:0]    res_rx;
    t_res_tag         res_tag;

    always_comb begin
        excl_k0 = sel[1] || sel[3];
        excl_j0 = sel[2] || sel[3];
        colok   = {1'b1, r_s2_edge.c_ge1, r_s2_edge.c_ge2};
        rowok   = {1'b1, r_s2_edge.r_ge1, r_s2_edge.r_ge2};
        sum_r   = '0;
        sum_g   = '0;
        sum_b   = '0;
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                if (colok[k] && rowok[j] && !(k == 0 && excl_k0) && !(j == 0 && excl_j0)) begin
                    sum_r = sum_r + SUM_W'(r_win[j*3+k][23:16]);
                    sum_g = sum_g + SUM_W'(r_win[j*3+k][15:8]);
                    sum_b = sum_b + SUM_W'(r_win[j*3+k][7:0]);
                end
            end
        end

        // Up-left and left results sit one column back, upper ones one row up.
        res_c  = excl_k0 ? r_s2_c : r_s2_c - CW'(1);
        res_r  = excl_j0 ? r_s2_r : r_s2_r - RW'(1);
        res_cx = XC'(res_c);
        res_rx = XR'(res_r);

        res_tag.col  = res_cx[POS_W-1:0];
        res_tag.row  = res_rx[POS_W-1:0];
        res_tag.last = (pend_rest == '0);
        res_tag.done = sel[3];
    end

    // ------------------------------------------------------------------
    // Sum register and output register with the division by 9
    // ------------------------------------------------------------------
    logic             r_sum_valid;
    logic [SUM_W-1:0] r_sum_r, r_sum_g, r_sum_b;
    t_res_tag         r_sum_tag;
    logic             out_rdy;
    logic             r_out_valid;
    logic [55:0]      r_out_data;
    logic             r_out_last;
    logic             r_out_done;

    assign out_rdy = !r_out_valid || m_axis_tready;
    assign sum_rdy = !r_sum_valid || out_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid <= 1'b0;
        end else if (sum_rdy) begin
            r_sum_valid <= s2_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_emit) begin
            r_sum_r   <= sum_r;
            r_sum_g   <= sum_g;
            r_sum_b   <= sum_b;
            r_sum_tag <= res_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_rdy) begin
            r_out_valid <= r_sum_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy && r_sum_valid) begin
            r_out_data <= {4'd0, r_sum_tag.row, r_sum_tag.col,
                           div9(r_sum_r), div9(r_sum_g), div9(r_sum_b), ALPHA};
            r_out_last <= r_sum_tag.last;
            r_out_done <= r_sum_tag.done;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_done;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A pixel waiting for the window keeps its slot and its column.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_s1_c))
        else $error("stage 1 pixel lost while stalled");

    // Back-to-back accesses to one line store entry only happen in column 0.
    a_fwd_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_fwd |-> r_s1_valid && (r_s1_c == '0))
        else $error("line store forwarding outside column 0");

    // A stalled sum register keeps its result.
    a_sum_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum_valid && !out_rdy |=> r_sum_valid && $stable(r_sum_tag))
        else $error("sum register changed while stalled");

    // The bottom-right result is always the last result of its input.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("frame end result not marked last");

endmodule
